[rtl/core/clnp_pkg.sv]
// ----------------------------------------------------------------------------
// clnp_pkg
// Types, constants and helper functions for the character LCD nibble port
// driver.
// ----------------------------------------------------------------------------
`default_nettype none

package clnp_pkg;

  // Port image bits
  localparam logic [7:0] RS_BIT        = 8'h01;
  localparam logic [7:0] RS_CLEAR_MASK = 8'hFE;
  localparam logic [7:0] EN_BIT        = 8'h02;
  localparam logic [7:0] EN_CLEAR_MASK = 8'hFD;
  localparam logic [7:0] LED0_BIT      = 8'h04;
  localparam logic [7:0] LED1_BIT      = 8'h08;
  localparam logic [7:0] DATA_MASK     = 8'hF0;
  localparam logic [7:0] CTRL_MASK     = 8'h0F;

  // LCD commands
  localparam logic [7:0] CMD_DDRAM = 8'h80;
  localparam logic [7:0] CMD_CLEAR = 8'h01;

  localparam logic [6:0] LINE_COLUMNS = 7'd40;
  localparam logic [2:0] LINE_COUNT_RESET = 3'd2;

  // Steps in one byte write
  localparam logic [3:0] BYTE_STEPS = 4'd7;
  localparam logic [3:0] LAST_STEP_LED   = 4'd0;
  localparam logic [3:0] LAST_STEP_BYTE  = 4'd6;
  localparam logic [3:0] LAST_STEP_GOTO  = 4'd13;

  typedef enum logic [2:0] {
    FUNC_CMD        = 3'd0,
    FUNC_DATA       = 3'd1,
    FUNC_CHAR       = 3'd2,
    FUNC_GOTO       = 3'd3,
    FUNC_CLEAR      = 3'd4,
    FUNC_LED_ON     = 3'd5,
    FUNC_LED_OFF    = 3'd6,
    FUNC_LED_TOGGLE = 3'd7
  } func_e;

  typedef enum logic [1:0] {
    LED_SET = 2'd0,
    LED_CLR = 2'd1,
    LED_TGL = 2'd2
  } led_op_e;

  typedef struct packed {
    func_e      func;
    logic [7:0] value;
    logic [5:0] col;
    logic [1:0] row;
    logic       led_select;
  } in_item_t;

  typedef struct packed {
    logic [7:0] port_value;
    logic       last;
  } out_item_t;

  // Run descriptor handed from decode to the sequencer
  typedef struct packed {
    logic       is_led;
    led_op_e    led_op;
    logic [7:0] led_mask;
    logic       rs;
    logic [7:0] byte1;
    logic       has_goto;
    logic [7:0] byte2;
  } run_t;

  function automatic logic [7:0] row_offset(input logic [1:0] row);
    logic [7:0] off;
    unique case (row)
      2'd0:    off = 8'h00;
      2'd1:    off = 8'h40;
      2'd2:    off = 8'h14;
      default: off = 8'h54;
    endcase
    return off;
  endfunction

  // Port image for one step of a byte write
  function automatic logic [7:0] byte_image(input logic [7:0] img,
                                            input logic [2:0] sub,
                                            input logic       rs,
                                            input logic [7:0] data);
    logic [7:0] res;
    case (sub)
      3'd0:    res = img & EN_CLEAR_MASK;
      3'd1:    res = rs ? (img | RS_BIT) : (img & RS_CLEAR_MASK);
      3'd2:    res = img | EN_BIT;
      3'd3:    res = ({data[7:4], 4'h0} & DATA_MASK) | (img & CTRL_MASK);
      3'd4:    res = img & EN_CLEAR_MASK;
      3'd5:    res = img | EN_BIT;
      3'd6:    res = ({data[3:0], 4'h0} & DATA_MASK) | (img & CTRL_MASK);
      default: res = img;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/core/clnp_cursor.sv]
// ----------------------------------------------------------------------------
// clnp_cursor
// Cursor tracking and item decode: turns an accepted item into a run
// descriptor and updates the cursor column and row.
// ----------------------------------------------------------------------------
`default_nettype none

module clnp_cursor
  import clnp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire in_item_t   item_i,
  input  wire logic [2:0] line_count_i,
  output run_t            run_o
);

  logic [5:0] col_q, col_d;
  logic [1:0] row_q, row_d;
  logic [6:0] next_col;
  logic [2:0] next_row;

  always_comb begin
    next_col = {1'b0, col_q} + 7'd1;
    next_row = {1'b0, row_q} + 3'd1;
    if (next_row >= line_count_i) begin
      next_row = 3'd0;
    end

    run_o          = '0;
    run_o.led_mask = item_i.led_select ? LED1_BIT : LED0_BIT;
    col_d          = col_q;
    row_d          = row_q;

    unique case (item_i.func)
      FUNC_CMD: begin
        run_o.byte1 = item_i.value;
      end
      FUNC_DATA: begin
        run_o.rs    = 1'b1;
        run_o.byte1 = item_i.value;
      end
      FUNC_CHAR: begin
        run_o.rs    = 1'b1;
        run_o.byte1 = item_i.value;
        if (next_col >= LINE_COLUMNS) begin
          run_o.has_goto = 1'b1;
          run_o.byte2    = CMD_DDRAM | row_offset(next_row[1:0]);
          col_d          = 6'd0;
          row_d          = next_row[1:0];
        end else begin
          col_d = next_col[5:0];
        end
      end
      FUNC_GOTO: begin
        run_o.byte1 = CMD_DDRAM | (row_offset(item_i.row) + {2'b00, item_i.col});
        col_d       = item_i.col;
        row_d       = item_i.row;
      end
      FUNC_CLEAR: begin
        run_o.byte1 = CMD_CLEAR;
        col_d       = 6'd0;
        row_d       = 2'd0;
      end
      FUNC_LED_ON: begin
        run_o.is_led = 1'b1;
        run_o.led_op = LED_SET;
      end
      FUNC_LED_OFF: begin
        run_o.is_led = 1'b1;
        run_o.led_op = LED_CLR;
      end
      FUNC_LED_TOGGLE: begin
        run_o.is_led = 1'b1;
        run_o.led_op = LED_TGL;
      end
      default: begin
        run_o.is_led = 1'b1;
        run_o.led_op = LED_TGL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/clnp_sequencer.sv]
// ----------------------------------------------------------------------------
// clnp_sequencer
// Holds the current run, steps through its port images one per cycle while
// the output is not stalled, and keeps the port image and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module clnp_sequencer
  import clnp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire run_t      run_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_data_o
);

  run_t       run_q;
  logic       busy_q;
  logic [3:0] step_q;
  logic [7:0] img_q, img_d;
  logic       out_valid_q;
  out_item_t  out_data_q;

  logic       advance;
  logic       last_step;
  logic [3:0] last_idx;
  logic [3:0] sub;
  logic       second;
  logic       accept;

  always_comb begin
    if (run_q.is_led) begin
      last_idx = LAST_STEP_LED;
    end else if (run_q.has_goto) begin
      last_idx = LAST_STEP_GOTO;
    end else begin
      last_idx = LAST_STEP_BYTE;
    end
    last_step = (step_q == last_idx);
    advance   = busy_q && (!out_valid_q || out_ready_i);
    second    = (step_q >= BYTE_STEPS);
    sub       = second ? (step_q - BYTE_STEPS) : step_q;

    if (run_q.is_led) begin
      unique case (run_q.led_op)
        LED_SET: img_d = img_q | run_q.led_mask;
        LED_CLR: img_d = img_q & ~run_q.led_mask;
        LED_TGL: img_d = img_q ^ run_q.led_mask;
        default: img_d = img_q;
      endcase
    end else if (second) begin
      img_d = byte_image(img_q, sub[2:0], 1'b0, run_q.byte2);
    end else begin
      img_d = byte_image(img_q, sub[2:0], run_q.rs, run_q.byte1);
    end
  end

  assign in_ready_o  = !busy_q || (advance && last_step);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      run_q  <= '0;
    end else if (accept) begin
      busy_q <= 1'b1;
      step_q <= '0;
      run_q  <= run_i;
    end else if (advance) begin
      if (last_step) begin
        busy_q <= 1'b0;
      end else begin
        step_q <= step_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      img_q       <= img_d;
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q.port_value <= img_d;
      out_data_q.last       <= last_step;
    end
  end

endmodule

`default_nettype wire

[rtl/core/char_lcd_nibble_port_driver.sv]
// ----------------------------------------------------------------------------
// char_lcd_nibble_port_driver
// Character LCD driver in 4-bit mode through one 8-bit port image, with
// cursor tracking, line wrap and LED control.
// ----------------------------------------------------------------------------
// An item is loaded into the run register, its first port image then into
// the output register. One port image per cycle while the output is not
// stalled; an item yields 1 (LED), 7 (byte, goto, clear) or 14 (tracked
// character with wrap) port images, set by the step counter of the run
// sequencer. The next item is taken while the last image of the current
// run is loaded. Reset clears image and cursor and sets line count to 2.
`default_nettype none

module char_lcd_nibble_port_driver
  import clnp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [2:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire in_item_t   in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output out_item_t       out_data_o
);

  logic [2:0] line_count_q;
  run_t       run;
  logic       accept;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_count_q <= LINE_COUNT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      line_count_q <= cfg_data_i;
    end
  end

  clnp_cursor u_cursor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .item_i       (in_data_i),
    .line_count_i (line_count_q),
    .run_o        (run)
  );

  clnp_sequencer u_sequencer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .run_i       (run),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // an accepted transaction leads to valid output
  a_accept_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##2 out_valid_o)
    else $error("no output after accepted transaction");

  // mid-run stall blocks new transactions
  a_stall_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i && !out_data_o.last |-> !in_ready_o)
    else $error("input taken while run stalled");

  // a run continues without gaps
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last |=> out_valid_o)
    else $error("gap inside a run");

endmodule

`default_nettype wire
